>>> src/lbe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the Lagrange basis evaluator.
package lbe_pkg;

    localparam int PT_W          = 16;
    localparam int DIFF_W        = PT_W + 1;
    localparam int LIMB_W        = 32;
    localparam int OUT_FRAC      = 16;
    localparam int VAL_W         = 32;
    localparam int IDX_OUT_W     = 3;
    localparam int CNT_RAW_W     = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int MIN_POINTS    = 2;
    localparam int PT_RESET_STEP = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_0     = 3'd1;

    localparam logic [VAL_W-1:0] VAL_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_NEG_SAT = 32'h8000_0000;

    typedef struct packed {
        logic clear;
        logic start;
    } t_mul_cmd;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             sat;
    } t_div_res;

endpackage

>>> src/lbe_cfg.sv
`timescale 1ns / 1ps
// Configuration registers: point count with clamping and the support point file.
module lbe_cfg #(
    parameter int MAX_POINTS = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lbe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lbe_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [$clog2(MAX_POINTS)-1:0]       i_rd_addr,
    output logic [$clog2(MAX_POINTS+1)-1:0]     o_count,
    output logic signed [lbe_pkg::PT_W-1:0]     o_point
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int IW = $clog2(MAX_POINTS + 1);

    logic [lbe_pkg::CNT_RAW_W-1:0]  r_count;
    logic signed [lbe_pkg::PT_W-1:0] r_pt [MAX_POINTS];
    logic [lbe_pkg::CFG_IDX_W-1:0]  wr_slot;
    logic                           wr_point;

    assign wr_slot  = i_cfg_index - lbe_pkg::REG_POINT_0;
    assign wr_point = i_cfg_we && (i_cfg_index >= lbe_pkg::REG_POINT_0)
                      && ({1'b0, wr_slot} < (lbe_pkg::CFG_IDX_W + 1)'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= lbe_pkg::CNT_RAW_W'(lbe_pkg::MIN_POINTS);
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_pt[k] <= lbe_pkg::PT_W'(k * lbe_pkg::PT_RESET_STEP);
            end
        end else begin
            if (i_cfg_we && (i_cfg_index == lbe_pkg::REG_POINT_COUNT)) begin
                r_count <= i_cfg_data[lbe_pkg::CNT_RAW_W-1:0];
            end
            if (wr_point) begin
                r_pt[wr_slot[AW-1:0]] <= i_cfg_data[lbe_pkg::PT_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_count < lbe_pkg::CNT_RAW_W'(lbe_pkg::MIN_POINTS)) begin
            o_count = IW'(lbe_pkg::MIN_POINTS);
        end else if (r_count > lbe_pkg::CNT_RAW_W'(MAX_POINTS)) begin
            o_count = IW'(MAX_POINTS);
        end else begin
            o_count = IW'(r_count);
        end
    end

    assign o_point = r_pt[i_rd_addr];

endmodule

>>> src/lbe_mul.sv
`timescale 1ns / 1ps
// Product accumulator that multiplies by one 17-bit factor a limb per cycle.
module lbe_mul #(
    parameter int LIMBS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lbe_pkg::t_mul_cmd                   i_cmd,
    input  logic [lbe_pkg::DIFF_W-1:0]          i_factor,
    output logic                                o_busy,
    output logic [LIMBS*lbe_pkg::LIMB_W-1:0]    o_acc
);

    localparam int ACC_W = LIMBS * lbe_pkg::LIMB_W;
    localparam int CW    = (LIMBS > 1) ? $clog2(LIMBS) : 1;
    localparam int PW    = lbe_pkg::LIMB_W + lbe_pkg::DIFF_W;

    logic [ACC_W-1:0]              r_acc;
    logic [lbe_pkg::DIFF_W-1:0]    r_factor;
    logic [lbe_pkg::DIFF_W-1:0]    r_carry;
    logic                          r_busy;
    logic [CW-1:0]                 r_cnt;
    logic [PW-1:0]                 prod;
    logic [ACC_W-1:0]              acc_rot;

    assign prod = PW'(r_acc[lbe_pkg::LIMB_W-1:0]) * PW'(r_factor) + PW'(r_carry);

    generate
        if (LIMBS > 1) begin : g_multi
            assign acc_rot = {prod[lbe_pkg::LIMB_W-1:0], r_acc[ACC_W-1:lbe_pkg::LIMB_W]};
        end else begin : g_single
            assign acc_rot = prod[lbe_pkg::LIMB_W-1:0];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(LIMBS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_acc <= ACC_W'(1);
        end else if (i_cmd.start) begin
            r_factor <= i_factor;
            r_carry  <= '0;
        end else if (r_busy) begin
            r_acc   <= acc_rot;
            r_carry <= prod[PW-1:lbe_pkg::LIMB_W];
        end
    end

    assign o_busy = r_busy;
    assign o_acc  = r_acc;

endmodule

>>> src/lbe_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, with rounding and saturation.
module lbe_div #(
    parameter int PROD_BITS = 102
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [PROD_BITS-1:0]    i_num,
    input  logic [PROD_BITS-1:0]    i_den,
    input  logic                    i_neg,
    output logic                    o_busy,
    output lbe_pkg::t_div_res       o_res
);

    localparam int NUM_BITS = PROD_BITS + lbe_pkg::OUT_FRAC;
    localparam int QW       = lbe_pkg::VAL_W + 1;
    localparam int DCW      = $clog2(NUM_BITS);

    logic [NUM_BITS-1:0]   r_num;
    logic [PROD_BITS-1:0]  r_den;
    logic [PROD_BITS-1:0]  r_rem;
    logic [QW-1:0]         r_q;
    logic [QW:0]           r_qr;
    logic                  r_big;
    logic                  r_neg;
    logic                  r_busy;
    logic                  r_round;
    logic [DCW-1:0]        r_cnt;

    logic [PROD_BITS:0]    rem_sh;
    logic [PROD_BITS+1:0]  sdiff;
    logic                  ge;
    logic [PROD_BITS+1:0]  rdiff;
    logic                  rnd;
    logic                  sat_pos;
    logic                  sat_neg;

    assign rem_sh = {r_rem, r_num[NUM_BITS-1]};
    assign sdiff  = {1'b0, rem_sh} - {2'b00, r_den};
    assign ge     = !sdiff[PROD_BITS+1];
    assign rdiff  = {1'b0, r_rem, 1'b0} - {2'b00, r_den};
    assign rnd    = !rdiff[PROD_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_round <= 1'b0;
            r_cnt   <= DCW'(NUM_BITS - 1);
        end else if (r_busy) begin
            if (r_round) begin
                r_busy  <= 1'b0;
                r_round <= 1'b0;
            end else if (r_cnt == '0) begin
                r_round <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_num, {lbe_pkg::OUT_FRAC{1'b0}}};
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_big <= 1'b0;
            r_neg <= i_neg;
        end else if (r_busy && r_round) begin
            r_qr <= {1'b0, r_q} + (QW + 1)'(rnd);
        end else if (r_busy) begin
            r_num <= {r_num[NUM_BITS-2:0], 1'b0};
            r_rem <= ge ? sdiff[PROD_BITS-1:0] : rem_sh[PROD_BITS-1:0];
            r_q   <= {r_q[QW-2:0], ge};
            r_big <= r_big | r_q[QW-1];
        end
    end

    assign sat_pos = r_big || (|r_qr[QW:QW-2]);
    assign sat_neg = r_big || (|r_qr[QW:QW-1]) || (r_qr[QW-2] && (|r_qr[QW-3:0]));

    always_comb begin
        if (r_neg) begin
            o_res.sat   = sat_neg;
            o_res.value = sat_neg ? lbe_pkg::VAL_NEG_SAT
                                  : (lbe_pkg::VAL_W)'(0) - r_qr[lbe_pkg::VAL_W-1:0];
        end else begin
            o_res.sat   = sat_pos;
            o_res.value = sat_pos ? lbe_pkg::VAL_POS_SAT : r_qr[lbe_pkg::VAL_W-1:0];
        end
    end

    assign o_busy = r_busy;

endmodule

>>> src/lagrange_basis_evaluator_top.sv
`timescale 1ns / 1ps
// Top level of the Lagrange basis evaluator: sequencer, output register and units.
// For each accepted eval_point the block emits one word per active support point,
// in index order, with last set on the final one; the input is stalled from the
// accept until the final word has been loaded into the output register. Each basis
// value is computed with the single 32x17 multiplier, which walks LIMBS =
// ceil(17*(MAX_POINTS-1)/32) 32-bit limbs per product factor, and with the
// restoring divider, which takes NUM_BITS = 17*(MAX_POINTS-1)+16 steps.
// Coinciding support points give a zero value with divide_error set.
module lagrange_basis_evaluator_top #(
    parameter int MAX_POINTS = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lbe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lbe_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [lbe_pkg::PT_W-1:0]     i_eval_point,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lbe_pkg::IDX_OUT_W-1:0]       o_basis_index,
    output logic signed [lbe_pkg::VAL_W-1:0]    o_basis_value,
    output logic                                o_saturated,
    output logic                                o_divide_error,
    output logic                                o_last
);

    localparam int AW        = $clog2(MAX_POINTS);
    localparam int IW        = $clog2(MAX_POINTS + 1);
    localparam int PROD_BITS = lbe_pkg::DIFF_W * (MAX_POINTS - 1);
    localparam int LIMBS     = (PROD_BITS + lbe_pkg::LIMB_W - 1) / lbe_pkg::LIMB_W;
    localparam int ACC_W     = LIMBS * lbe_pkg::LIMB_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PI    = 9'b000000010,
        S_DEN   = 9'b000000100,
        S_DWAIT = 9'b000001000,
        S_NUM   = 9'b000010000,
        S_NWAIT = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_QWAIT = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state                          r_state, n_state;
    logic signed [lbe_pkg::PT_W-1:0] r_x, n_x;
    logic signed [lbe_pkg::PT_W-1:0] r_pi, n_pi;
    logic [IW-1:0]                   r_i, n_i;
    logic [IW-1:0]                   r_j, n_j;
    logic                            r_neg, n_neg;
    logic [PROD_BITS-1:0]            r_den, n_den;
    logic                            r_err, n_err;
    logic                            r_nz, n_nz;

    logic                               r_out_valid;
    logic [lbe_pkg::IDX_OUT_W-1:0]      r_out_index;
    logic [lbe_pkg::VAL_W-1:0]          r_out_value;
    logic                               r_out_sat;
    logic                               r_out_err;
    logic                               r_out_last;

    logic [IW-1:0]                   active_cnt;
    logic [AW-1:0]                   rd_addr;
    logic signed [lbe_pkg::PT_W-1:0] pt_rd;
    logic signed [lbe_pkg::PT_W-1:0] opnd_a;
    logic [lbe_pkg::DIFF_W-1:0]      diff;
    logic [lbe_pkg::DIFF_W-1:0]      diff_mag;
    logic                            diff_neg;
    lbe_pkg::t_mul_cmd               mul_cmd;
    logic                            mul_busy;
    logic [ACC_W-1:0]                mul_acc;
    logic                            div_start;
    logic                            div_busy;
    lbe_pkg::t_div_res               div_res;
    logic                            den_zero;
    logic                            num_zero;
    logic                            out_free;
    logic                            out_load;
    logic                            is_last;

    lbe_cfg #(
        .MAX_POINTS (MAX_POINTS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rd_addr   (rd_addr),
        .o_count     (active_cnt),
        .o_point     (pt_rd)
    );

    lbe_mul #(
        .LIMBS (LIMBS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (mul_cmd),
        .i_factor (diff_mag),
        .o_busy   (mul_busy),
        .o_acc    (mul_acc)
    );

    lbe_div #(
        .PROD_BITS (PROD_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mul_acc[PROD_BITS-1:0]),
        .i_den   (r_den),
        .i_neg   (r_neg),
        .o_busy  (div_busy),
        .o_res   (div_res)
    );

    assign rd_addr  = (r_state == S_PI) ? r_i[AW-1:0] : r_j[AW-1:0];
    assign opnd_a   = (r_state == S_NUM) ? r_x : r_pi;
    assign diff     = {opnd_a[lbe_pkg::PT_W-1], opnd_a} - {pt_rd[lbe_pkg::PT_W-1], pt_rd};
    assign diff_neg = diff[lbe_pkg::DIFF_W-1];
    assign diff_mag = diff_neg ? (lbe_pkg::DIFF_W)'(0) - diff : diff;

    assign den_zero = (r_den == '0);
    assign num_zero = (mul_acc[PROD_BITS-1:0] == '0);
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_OUT) && out_free;
    assign is_last  = (IW'(r_i + 1'b1) == active_cnt);

    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_pi      = r_pi;
        n_i       = r_i;
        n_j       = r_j;
        n_neg     = r_neg;
        n_den     = r_den;
        n_err     = r_err;
        n_nz      = r_nz;
        mul_cmd   = '0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x     = i_eval_point;
                    n_i     = '0;
                    n_state = S_PI;
                end
            end
            S_PI: begin
                n_pi          = pt_rd;
                n_j           = '0;
                n_neg         = 1'b0;
                mul_cmd.clear = 1'b1;
                n_state       = S_DEN;
            end
            S_DEN: begin
                if (r_j == active_cnt) begin
                    n_den         = mul_acc[PROD_BITS-1:0];
                    n_j           = '0;
                    mul_cmd.clear = 1'b1;
                    n_state       = S_NUM;
                end else if (r_j == r_i) begin
                    n_j = r_j + 1'b1;
                end else begin
                    mul_cmd.start = 1'b1;
                    n_neg         = r_neg ^ diff_neg;
                    n_state       = S_DWAIT;
                end
            end
            S_DWAIT: begin
                if (!mul_busy) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_DEN;
                end
            end
            S_NUM: begin
                if (r_j == active_cnt) begin
                    n_state = S_DIV;
                end else if (r_j == r_i) begin
                    n_j = r_j + 1'b1;
                end else begin
                    mul_cmd.start = 1'b1;
                    n_neg         = r_neg ^ diff_neg;
                    n_state       = S_NWAIT;
                end
            end
            S_NWAIT: begin
                if (!mul_busy) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_NUM;
                end
            end
            S_DIV: begin
                n_err = den_zero;
                n_nz  = num_zero;
                if (!den_zero && !num_zero) begin
                    div_start = 1'b1;
                    n_state   = S_QWAIT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_QWAIT: begin
                if (!div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_PI;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_pi  <= n_pi;
        r_neg <= n_neg;
        r_den <= n_den;
        r_err <= n_err;
        r_nz  <= n_nz;
        if (out_load) begin
            r_out_index <= lbe_pkg::IDX_OUT_W'(r_i);
            r_out_value <= (r_err || r_nz) ? '0 : div_res.value;
            r_out_sat   <= (r_err || r_nz) ? 1'b0 : div_res.sat;
            r_out_err   <= r_err;
            r_out_last  <= is_last;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_basis_index  = r_out_index;
    assign o_basis_value  = r_out_value;
    assign o_saturated    = r_out_sat;
    assign o_divide_error = r_out_err;
    assign o_last         = r_out_last;

`ifndef SYNTH
    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_cmd.start |-> !mul_busy)
        else $error("Multiplier started while busy.");

    a_div_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !den_zero && !mul_busy)
        else $error("Divider started with a zero denominator or a busy multiplier.");

    a_idle_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mul_busy && !div_busy)
        else $error("Arithmetic unit busy while the sequencer is idle.");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && is_last) |=> (r_state == S_IDLE) && o_out_valid && o_last)
        else $error("Final word did not end the item.");
`endif

endmodule

>>> tb/lagrange_basis_evaluator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Lagrange basis evaluator top level.
module lagrange_basis_evaluator_top_tb;

    localparam int NUM_PTS       = 7;
    localparam int RANDOM_ITEMS  = 130;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 200;

    typedef logic signed [lbe_pkg::PT_W-1:0] t_point_set [NUM_PTS];

    typedef struct {
        logic [lbe_pkg::IDX_OUT_W-1:0]    index;
        logic signed [lbe_pkg::VAL_W-1:0] value;
        logic                             sat;
        logic                             div_err;
        logic                             last;
    } t_basis_word;

    typedef enum int {RX_FLOW, RX_PERIODIC, RX_RANDOM} t_rx_mode;
    typedef enum int {SET_SCATTER, SET_CLUSTER, SET_GRID, SET_REPEAT} t_set_style;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [lbe_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [lbe_pkg::CFG_DATA_W-1:0]   i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_stall;
    logic signed [lbe_pkg::PT_W-1:0]  i_eval_point;
    logic                             o_out_valid;
    logic                             i_out_stall;
    logic [lbe_pkg::IDX_OUT_W-1:0]    o_basis_index;
    logic signed [lbe_pkg::VAL_W-1:0] o_basis_value;
    logic                             o_saturated;
    logic                             o_divide_error;
    logic                             o_last;

    logic [lbe_pkg::CNT_RAW_W-1:0]    count_reg;
    logic signed [lbe_pkg::PT_W-1:0]  pt_reg [NUM_PTS];
    t_basis_word                      basis_words_q [$];

    int fail_count    = 0;
    int points_sent   = 0;
    int words_checked = 0;
    int sat_seen      = 0;
    int err_seen      = 0;
    int settings_used = 0;
    int burst_left    = 0;

    t_rx_mode rx_mode       = RX_FLOW;
    int       rx_phase_left = 0;
    int       rx_tick       = 0;

    lagrange_basis_evaluator_top #(
        .MAX_POINTS(NUM_PTS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_eval_point   (i_eval_point),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_basis_index  (o_basis_index),
        .o_basis_value  (o_basis_value),
        .o_saturated    (o_saturated),
        .o_divide_error (o_divide_error),
        .o_last         (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int active_count();
        if (count_reg < lbe_pkg::MIN_POINTS) begin
            return lbe_pkg::MIN_POINTS;
        end
        if (count_reg > NUM_PTS) begin
            return NUM_PTS;
        end
        return int'(count_reg);
    endfunction

    function automatic t_basis_word basis_at(input logic signed [lbe_pkg::PT_W-1:0] x,
                                             input int i, input int n);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] rem;
        logic         neg;
        int           d;
        t_basis_word  w;
        num = 128'd1;
        den = 128'd1;
        neg = 1'b0;
        for (int j = 0; j < n; j++) begin
            if (j != i) begin
                d = int'(x) - int'(pt_reg[j]);
                if (d < 0) begin
                    neg = ~neg;
                    d = -d;
                end
                num = num * 128'(d);
                d = int'(pt_reg[i]) - int'(pt_reg[j]);
                if (d < 0) begin
                    neg = ~neg;
                    d = -d;
                end
                den = den * 128'(d);
            end
        end
        w.index   = lbe_pkg::IDX_OUT_W'(i);
        w.value   = '0;
        w.sat     = 1'b0;
        w.div_err = 1'b0;
        w.last    = (i == n - 1);
        if (den == 0) begin
            w.div_err = 1'b1;
        end else if (num != 0) begin
            num = num << lbe_pkg::OUT_FRAC;
            quo = num / den;
            rem = num % den;
            if ((rem << 1) >= den) begin
                quo = quo + 128'd1;
            end
            if (neg) begin
                if (quo > 128'h8000_0000) begin
                    w.value = lbe_pkg::VAL_NEG_SAT;
                    w.sat   = 1'b1;
                end else begin
                    w.value = -quo[lbe_pkg::VAL_W-1:0];
                end
            end else begin
                if (quo > 128'h7FFF_FFFF) begin
                    w.value = lbe_pkg::VAL_POS_SAT;
                    w.sat   = 1'b1;
                end else begin
                    w.value = quo[lbe_pkg::VAL_W-1:0];
                end
            end
        end
        return w;
    endfunction

    task automatic cfg_write(input logic [lbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lbe_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == lbe_pkg::REG_POINT_COUNT) begin
            count_reg = data[lbe_pkg::CNT_RAW_W-1:0];
        end else begin
            pt_reg[idx - lbe_pkg::REG_POINT_0] = data;
        end
    endtask

    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (basis_words_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [lbe_pkg::CFG_DATA_W-1:0] count_word,
                                 input t_point_set pts);
        drain_words();
        for (int k = 0; k < NUM_PTS; k++) begin
            cfg_write(lbe_pkg::REG_POINT_0 + lbe_pkg::CFG_IDX_W'(k), pts[k]);
        end
        cfg_write(lbe_pkg::REG_POINT_COUNT, count_word);
        settings_used++;
    endtask

    task automatic send_point(input logic signed [lbe_pkg::PT_W-1:0] x);
        int gap;
        int n;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 400) : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_eval_point <= x;
        do @(posedge i_clk); while (o_in_stall);
        n = active_count();
        for (int k = 0; k < n; k++) begin
            basis_words_q = {basis_words_q, basis_at(x, k, n)};
        end
        burst_left--;
        points_sent++;
    endtask

    function automatic logic signed [lbe_pkg::PT_W-1:0] pick_eval_point();
        int sel;
        int n;
        n = active_count();
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            return lbe_pkg::PT_W'($urandom);
        end else if (sel < 70) begin
            return lbe_pkg::PT_W'(int'(pt_reg[$urandom_range(0, n - 1)])
                                  + $urandom_range(0, 64) - 32);
        end else if (sel < 85) begin
            return pt_reg[$urandom_range(0, n - 1)];
        end
        case ($urandom_range(0, 3))
            0: begin
                return 16'sh8000;
            end
            1: begin
                return 16'sh7FFF;
            end
            2: begin
                return 16'sh0000;
            end
            default: begin
                return -16'sd1;
            end
        endcase
    endfunction

    task automatic test_reset_values();
        send_point(16'sh0000);
        send_point(16'sh1000);
        send_point(16'sh0800);
        send_point(16'sh7FFF);
        send_point(16'sh8000);
    endtask

    task automatic test_seven_points();
        t_point_set pts;
        pts = '{-16'sd12288, -16'sd8192, -16'sd4096, 16'sd0, 16'sd4096, 16'sd8192, 16'sd12288};
        apply_setting({13'h1FFF, 3'd7}, pts);
        send_point(16'sh1000);
        send_point(16'sh0A00);
        send_point(16'sh8000);
        send_point(16'sh7FFF);
    endtask

    task automatic test_count_clamp();
        t_point_set pts;
        pts = '{16'sd300, -16'sd700, 16'sd1500, 16'sd2500, 16'sd3500, 16'sd4500, 16'sd5500};
        apply_setting({13'h0AAA, 3'd0}, pts);
        send_point(16'sh0100);
        send_point(-16'sd700);
        apply_setting({13'h1555, 3'd1}, pts);
        send_point(16'sh2000);
    endtask

    task automatic test_saturation();
        t_point_set pts;
        pts = '{16'sd0, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6};
        apply_setting(16'd7, pts);
        send_point(16'sh7FFF);
        send_point(16'sh8000);
        send_point(16'sh0003);
        pts = '{16'sh8000, 16'sh7FFF, 16'sh8001, 16'sh7FFE, 16'sd0, 16'sd1, -16'sd1};
        apply_setting(16'd7, pts);
        send_point(16'sh4000);
    endtask

    task automatic test_divide_error();
        t_point_set pts;
        pts = '{16'sd100, 16'sd100, -16'sd5000, 16'sd7000, 16'sd0, 16'sd0, 16'sd0};
        apply_setting(16'd4, pts);
        send_point(16'sd100);
        send_point(16'sd2000);
        pts = '{16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'sd50};
        apply_setting(16'd3, pts);
        send_point(16'sd50);
        pts = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        apply_setting(16'd2, pts);
        send_point(16'sh8000);
        send_point(16'sh7FFF);
    endtask

    task automatic test_random_sets(input int n_items);
        t_point_set                     pts;
        logic [lbe_pkg::CFG_DATA_W-1:0] count_word;
        t_set_style                     style;
        int                             done_items;
        int                             batch;
        int                             base;
        int                             step;
        int                             n;
        int                             dup;
        done_items = 0;
        while (done_items < n_items) begin
            count_word = lbe_pkg::CFG_DATA_W'($urandom);
            if ($urandom_range(0, 1) == 0) begin
                count_word[lbe_pkg::CFG_DATA_W-1:lbe_pkg::CNT_RAW_W] = '0;
            end
            count_word[lbe_pkg::CNT_RAW_W-1:0] = lbe_pkg::CNT_RAW_W'(
                ($urandom_range(0, 9) < 2) ? $urandom_range(0, 1) : $urandom_range(2, 7));
            n = (count_word[lbe_pkg::CNT_RAW_W-1:0] < lbe_pkg::MIN_POINTS)
                ? lbe_pkg::MIN_POINTS : int'(count_word[lbe_pkg::CNT_RAW_W-1:0]);
            style = t_set_style'($urandom_range(0, 3));
            step = (style == SET_CLUSTER) ? $urandom_range(1, 16) : $urandom_range(256, 8192);
            base = (style == SET_CLUSTER) ? int'($urandom_range(0, 65535)) - 32768
                                          : -3 * step + int'($urandom_range(0, 4096)) - 2048;
            for (int k = 0; k < NUM_PTS; k++) begin
                pts[k] = (style == SET_SCATTER) ? lbe_pkg::PT_W'($urandom)
                                                : lbe_pkg::PT_W'(base + k * step);
            end
            if (style == SET_REPEAT) begin
                dup = $urandom_range(1, n - 1);
                pts[dup] = pts[$urandom_range(0, dup - 1)];
            end
            apply_setting(count_word, pts);
            batch = $urandom_range(5, 25);
            if (batch > n_items - done_items) begin
                batch = n_items - done_items;
            end
            repeat (batch) begin
                send_point(pick_eval_point());
                done_items++;
                if ($urandom_range(0, 19) == 0) begin
                    drain_words();
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_mode       <= t_rx_mode'($urandom_range(0, 2));
            rx_phase_left <= $urandom_range(50, 400);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            RX_FLOW: begin
                i_out_stall <= 1'b0;
            end
            RX_PERIODIC: begin
                i_out_stall <= (rx_tick % 5) < 2;
            end
            default: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
        endcase
        rx_tick <= rx_tick + 1;
    end

    always @(posedge i_clk) begin : check_words
        t_basis_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_checked++;
            sat_seen += int'(o_saturated);
            err_seen += int'(o_divide_error);
            if (basis_words_q.size() == 0) begin
                $error("unexpected word: basis_index %0d basis_value %0d", o_basis_index,
                       o_basis_value);
                fail_count++;
            end else begin
                want = basis_words_q.pop_front();
                if (o_basis_index !== want.index) begin
                    $error("basis_index: expected %0d, actual %0d", want.index, o_basis_index);
                    fail_count++;
                end
                if (o_basis_value !== want.value) begin
                    $error("basis_value: expected %0d, actual %0d", want.value, o_basis_value);
                    fail_count++;
                end
                if (o_saturated !== want.sat) begin
                    $error("saturated: expected %0d, actual %0d", want.sat, o_saturated);
                    fail_count++;
                end
                if (o_divide_error !== want.div_err) begin
                    $error("divide_error: expected %0d, actual %0d", want.div_err,
                           o_divide_error);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_eval_point = '0;
        count_reg    = lbe_pkg::CNT_RAW_W'(lbe_pkg::MIN_POINTS);
        for (int k = 0; k < NUM_PTS; k++) begin
            pt_reg[k] = lbe_pkg::PT_W'(k * lbe_pkg::PT_RESET_STEP);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_seven_points();
        test_count_clamp();
        test_saturation();
        test_divide_error();
        test_random_sets(RANDOM_ITEMS);
        drain_words();
        repeat (END_CYCLES) @(posedge i_clk);
        $display("Sent %0d eval points over %0d register settings; checked %0d basis words.",
                 points_sent, settings_used, words_checked);
        $display("Saturated words: %0d, divide-error words: %0d, mismatches: %0d.",
                 sat_seen, err_seen, fail_count);
        if (fail_count == 0) begin
            $display("lagrange_basis_evaluator_top_tb: PASS");
        end else begin
            $display("lagrange_basis_evaluator_top_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("lagrange_basis_evaluator_top_tb: FAIL");
        $finish;
    end

endmodule
